### rtl/core/p13s_pkg.sv
// Package: widths, node table and fixed-point helpers for the pyramid shape evaluator.
`timescale 1ns / 1ps
package p13s_pkg;

  localparam int FRAC_BITS = 15;
  localparam int CW = 18;                  // input coordinate width
  localparam int XW = CW + 1;              // coordinate after negation
  localparam int XI = (FRAC_BITS < 17) ? 17 - FRAC_BITS : 0;  // integer bits of |x|
  localparam int OW = 3 * XI + FRAC_BITS + 4;  // multiplier operand width
  localparam int PW = 6 * XI + FRAC_BITS + 5;  // full chain product width
  localparam int NW = 4;                   // node index width
  localparam int RW = 24;                  // coefficient width
  localparam logic [NW-1:0] LAST_NODE = NW'(12);

  localparam logic signed [OW-1:0] ONE_Q = OW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] COEF_MAX = PW'(8388607);
  localparam logic signed [PW-1:0] COEF_MIN = -PW'(8388608);

  typedef enum logic [1:0] {
    KIND_APEX,
    KIND_CORNER,
    KIND_AMID,
    KIND_BMID
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  swap;   // x taken from t, y from s
    logic  negx;
    logic  negy;
  } node_info_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] u;
  } q_head_t;

  function automatic node_info_t node_info(input logic [NW-1:0] idx);
    node_info_t n;
    n = '{kind: KIND_APEX, swap: 1'b0, negx: 1'b0, negy: 1'b0};
    case (idx)
      4'd0:    n = '{kind: KIND_APEX,   swap: 1'b0, negx: 1'b0, negy: 1'b0};
      4'd1:    n = '{kind: KIND_CORNER, swap: 1'b0, negx: 1'b1, negy: 1'b1};
      4'd2:    n = '{kind: KIND_CORNER, swap: 1'b0, negx: 1'b0, negy: 1'b1};
      4'd3:    n = '{kind: KIND_CORNER, swap: 1'b0, negx: 1'b0, negy: 1'b0};
      4'd4:    n = '{kind: KIND_CORNER, swap: 1'b0, negx: 1'b1, negy: 1'b0};
      4'd5:    n = '{kind: KIND_AMID,   swap: 1'b0, negx: 1'b1, negy: 1'b1};
      4'd6:    n = '{kind: KIND_AMID,   swap: 1'b0, negx: 1'b0, negy: 1'b1};
      4'd7:    n = '{kind: KIND_AMID,   swap: 1'b0, negx: 1'b0, negy: 1'b0};
      4'd8:    n = '{kind: KIND_AMID,   swap: 1'b0, negx: 1'b1, negy: 1'b0};
      4'd9:    n = '{kind: KIND_BMID,   swap: 1'b0, negx: 1'b0, negy: 1'b1};
      4'd10:   n = '{kind: KIND_BMID,   swap: 1'b1, negx: 1'b0, negy: 1'b0};
      4'd11:   n = '{kind: KIND_BMID,   swap: 1'b0, negx: 1'b0, negy: 1'b0};
      4'd12:   n = '{kind: KIND_BMID,   swap: 1'b1, negx: 1'b0, negy: 1'b1};
      default: n = '{kind: KIND_APEX,   swap: 1'b0, negx: 1'b0, negy: 1'b0};
    endcase
    return n;
  endfunction

  // exact product, rounded to FRAC_BITS fraction bits, ties away from zero
  function automatic logic signed [PW-1:0] qmul(input logic signed [OW-1:0] a,
                                                input logic signed [OW-1:0] b);
    logic signed [2*OW-1:0] p;
    logic [2*OW-1:0]        m;
    logic [2*OW-1:0]        r;
    logic signed [PW-1:0]   rm;
    p  = (2*OW)'(a) * (2*OW)'(b);
    m  = p[2*OW-1] ? (~p + (2*OW)'(1)) : p;
    r  = (m + ((2*OW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rm = $signed(r[PW-1:0]);
    return p[2*OW-1] ? -rm : rm;
  endfunction

  function automatic logic signed [OW-1:0] qmul_o(input logic signed [OW-1:0] a,
                                                  input logic signed [OW-1:0] b);
    logic signed [PW-1:0] r;
    r = qmul(a, b);
    return $signed(r[OW-1:0]);
  endfunction

  // divide by 2^k, rounded to nearest, ties away from zero
  function automatic logic signed [PW-1:0] qscale(input logic signed [PW-1:0] v,
                                                  input int unsigned k);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = v[PW-1] ? (~v + PW'(1)) : v;
    r = (m + (PW'(1) << (k - 1))) >> k;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [RW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = v;
    if (v > COEF_MAX) c = COEF_MAX;
    if (v < COEF_MIN) c = COEF_MIN;
    return $signed(c[RW-1:0]);
  endfunction

endpackage

### rtl/core/p13s_front.sv
// Front part: accepts points into a two-entry queue ahead of the evaluator.
`timescale 1ns / 1ps
module p13s_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [p13s_pkg::CW-1:0] in_coord_s,
  input  logic signed [p13s_pkg::CW-1:0] in_coord_t,
  input  logic signed [p13s_pkg::CW-1:0] in_coord_u,
  output p13s_pkg::q_head_t              head,
  input  logic                           pop
);

  logic signed [p13s_pkg::CW-1:0] s_r [2];
  logic signed [p13s_pkg::CW-1:0] t_r [2];
  logic signed [p13s_pkg::CW-1:0] u_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       do_pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.s     = s_r[rp_r];
  assign head.t     = t_r[rp_r];
  assign head.u     = u_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s_r[wp_r] <= in_coord_s;
      t_r[wp_r] <= in_coord_t;
      u_r[wp_r] <= in_coord_u;
    end
  end

endmodule

### rtl/core/p13s_back.sv
// Back part: node sequencer and multiply pipeline producing one coefficient per cycle while not stalled.
`timescale 1ns / 1ps
module p13s_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  p13s_pkg::q_head_t              head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [p13s_pkg::NW-1:0]        out_node_index,
  output logic signed [p13s_pkg::RW-1:0] out_coefficient,
  output logic                           out_last_node
);

  localparam int OW = p13s_pkg::OW;
  localparam int PW = p13s_pkg::PW;
  localparam int XW = p13s_pkg::XW;
  localparam int NW = p13s_pkg::NW;
  localparam logic signed [OW-1:0] ONE = p13s_pkg::ONE_Q;

  logic adv;
  logic issue;
  logic [NW-1:0] k_r, k_nxt;
  p13s_pkg::node_info_t ni;
  logic signed [XW-1:0] sx, tx, xsel, ysel;

  // stage A
  logic a_v_r;
  p13s_pkg::kind_t a_kind_r;
  logic [NW-1:0] a_idx_r;
  logic signed [XW-1:0] a_x_r, a_y_r, a_u_r;
  // stage B
  logic b_v_r;
  p13s_pkg::kind_t b_kind_r;
  logic [NW-1:0] b_idx_r;
  logic signed [OW-1:0] b_x_r, b_y_r, b_u_r, b_xy_r, b_xu_r, b_yu_r, b_xx_r, b_uu_r, b_p1_r;
  logic signed [OW-1:0] xe, ye, ue, p1_nxt;
  // stage C
  logic c_v_r;
  p13s_pkg::kind_t c_kind_r;
  logic [NW-1:0] c_idx_r;
  logic signed [OW-1:0] c_u_r, c_xyu_r, c_m2_r, c_br_r;
  logic signed [OW-1:0] m2_nxt, br_c_nxt;
  // stage D
  logic d_v_r;
  p13s_pkg::kind_t d_kind_r;
  logic [NW-1:0] d_idx_r;
  logic signed [PW-1:0] d_m3_r, m3_nxt;
  logic signed [OW-1:0] d_br_r, br_full;
  // stage E
  logic e_v_r;
  p13s_pkg::kind_t e_kind_r;
  logic [NW-1:0] e_idx_r;
  logic signed [PW-1:0] e_m4_r, m4_nxt, scaled;
  // output
  logic out_valid_r;
  logic [NW-1:0] out_idx_r;
  logic signed [p13s_pkg::RW-1:0] out_coef_r;

  assign adv   = !out_valid_r || out_ready;
  assign issue = adv && head.valid;
  assign pop   = issue && (k_r == p13s_pkg::LAST_NODE);
  assign k_nxt = pop ? '0 : (issue ? k_r + NW'(1) : k_r);

  // pick and sign the node's local coordinates
  always_comb begin
    ni   = p13s_pkg::node_info(k_r);
    sx   = XW'(head.s);
    tx   = XW'(head.t);
    xsel = ni.swap ? tx : sx;
    ysel = ni.swap ? sx : tx;
    if (ni.negx) xsel = -xsel;
    if (ni.negy) ysel = -ysel;
  end

  // stage A -> B: first products
  always_comb begin
    xe = OW'(a_x_r);
    ye = OW'(a_y_r);
    ue = OW'(a_u_r);
    if (a_kind_r == p13s_pkg::KIND_APEX) p1_nxt = p13s_pkg::qmul_o(ue, ONE + ue);
    else p1_nxt = p13s_pkg::qmul_o(ONE + xe, ONE + ye);
  end

  // stage B -> C: second products and bracket sums
  always_comb begin
    case (b_kind_r)
      p13s_pkg::KIND_CORNER: m2_nxt = p13s_pkg::qmul_o(b_p1_r, ONE - b_u_r);
      p13s_pkg::KIND_AMID:   m2_nxt = p13s_pkg::qmul_o(b_p1_r, ONE - b_uu_r);
      p13s_pkg::KIND_BMID:   m2_nxt = p13s_pkg::qmul_o(ONE - b_xx_r, ONE + b_y_r);
      default:               m2_nxt = b_p1_r;
    endcase
    if (b_kind_r == p13s_pkg::KIND_CORNER) begin
      br_c_nxt = (ONE <<< 2) - ((b_x_r <<< 1) + b_x_r) - ((b_y_r <<< 1) + b_y_r)
               + (b_xy_r <<< 1) + (b_u_r <<< 1) - b_xu_r - b_yu_r;
    end else begin
      br_c_nxt = (ONE <<< 1) - b_y_r - b_yu_r;
    end
  end

  // stage C -> D
  always_comb begin
    br_full = (c_kind_r == p13s_pkg::KIND_CORNER) ? c_br_r + (c_xyu_r <<< 1) : c_br_r;
    case (c_kind_r)
      p13s_pkg::KIND_CORNER: m3_nxt = p13s_pkg::qmul(c_m2_r, br_full);
      p13s_pkg::KIND_BMID:   m3_nxt = p13s_pkg::qmul(c_m2_r, ONE - c_u_r);
      default:               m3_nxt = PW'(c_m2_r);
    endcase
  end

  // stage D -> E and final scale
  always_comb begin
    if (d_kind_r == p13s_pkg::KIND_BMID) m4_nxt = p13s_pkg::qmul($signed(d_m3_r[OW-1:0]), d_br_r);
    else m4_nxt = d_m3_r;
    case (e_kind_r)
      p13s_pkg::KIND_APEX:   scaled = p13s_pkg::qscale(e_m4_r, 1);
      p13s_pkg::KIND_CORNER: scaled = -p13s_pkg::qscale(e_m4_r, 4);
      p13s_pkg::KIND_AMID:   scaled = p13s_pkg::qscale(e_m4_r, 2);
      default:               scaled = p13s_pkg::qscale(e_m4_r, 3);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      if (adv) begin
        a_v_r       <= issue;
        b_v_r       <= a_v_r;
        c_v_r       <= b_v_r;
        d_v_r       <= c_v_r;
        e_v_r       <= d_v_r;
        out_valid_r <= e_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r   <= ni.kind;
      a_idx_r    <= k_r;
      a_x_r      <= xsel;
      a_y_r      <= ysel;
      a_u_r      <= XW'(head.u);

      b_kind_r   <= a_kind_r;
      b_idx_r    <= a_idx_r;
      b_x_r      <= xe;
      b_y_r      <= ye;
      b_u_r      <= ue;
      b_xy_r     <= p13s_pkg::qmul_o(xe, ye);
      b_xu_r     <= p13s_pkg::qmul_o(xe, ue);
      b_yu_r     <= p13s_pkg::qmul_o(ye, ue);
      b_xx_r     <= p13s_pkg::qmul_o(xe, xe);
      b_uu_r     <= p13s_pkg::qmul_o(ue, ue);
      b_p1_r     <= p1_nxt;

      c_kind_r   <= b_kind_r;
      c_idx_r    <= b_idx_r;
      c_u_r      <= b_u_r;
      c_xyu_r    <= p13s_pkg::qmul_o(b_xy_r, b_u_r);
      c_m2_r     <= m2_nxt;
      c_br_r     <= br_c_nxt;

      d_kind_r   <= c_kind_r;
      d_idx_r    <= c_idx_r;
      d_m3_r     <= m3_nxt;
      d_br_r     <= br_full;

      e_kind_r   <= d_kind_r;
      e_idx_r    <= d_idx_r;
      e_m4_r     <= m4_nxt;

      out_idx_r  <= e_idx_r;
      out_coef_r <= p13s_pkg::sat(scaled);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_idx_r;
  assign out_coefficient = out_coef_r;
  assign out_last_node   = (out_idx_r == p13s_pkg::LAST_NODE);

endmodule

### rtl/core/pyramid13_shape_function_eval.sv
// Top level: 13-node pyramid shape function evaluator.
//
//   channel | direction | payload
//   in_     | input     | coord_s, coord_t, coord_u (18-bit signed, Q.15)
//   out_    | output    | node_index (4), coefficient (24 signed), last_node
//
// Each point yields 13 results, one per cycle while the output is not stalled;
// the node sequencer in the back part sets that pace.
// The first result of a point passes the queue write, then stages A to E, then
// the output register.
// Reset is synchronous and clears the queue, sequencer and pipeline valids.
// A stalled output freezes the whole pipeline; the queue keeps taking points until it holds two.
`timescale 1ns / 1ps
module pyramid13_shape_function_eval (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [p13s_pkg::CW-1:0] in_coord_s,
  input  logic signed [p13s_pkg::CW-1:0] in_coord_t,
  input  logic signed [p13s_pkg::CW-1:0] in_coord_u,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [p13s_pkg::NW-1:0]        out_node_index,
  output logic signed [p13s_pkg::RW-1:0] out_coefficient,
  output logic                           out_last_node
);

  p13s_pkg::q_head_t head;
  logic              pop;

  p13s_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_coord_s (in_coord_s),
    .in_coord_t (in_coord_t),
    .in_coord_u (in_coord_u),
    .head       (head),
    .pop        (pop)
  );

  p13s_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_index  (out_node_index),
    .out_coefficient (out_coefficient),
    .out_last_node   (out_last_node)
  );

endmodule

### tb/tb.sv
// Testbench for the 13-node pyramid shape function evaluator.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [3:0]         node;
    logic signed [23:0] coef;
    logic               last;
  } shape_res_t;

  typedef struct {
    logic signed [17:0] s, t, u;
    bit                 typed;   // coefficients typed in below
    int                 c0, c1;  // apex and corner 3 values
  } point_row_t;

  localparam longint ONE = 64'sd1 << 15;
  localparam int N_RANDOM = 190;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_last_node;
  logic signed [17:0] in_coord_s, in_coord_t, in_coord_u;
  logic [3:0] out_node_index;
  logic signed [23:0] out_coefficient;

  shape_res_t coef_queue[$];
  int errors = 0, n_points = 0, n_results = 0;
  bit drain = 0;

  pyramid13_shape_function_eval dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // rounded Q15 product, ties away from zero; values here stay far below 64 bits
  function automatic longint fx_mul(longint a, longint b);
    longint m;
    bit neg;
    neg = (a < 0) != (b < 0);
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'sd1 << 14)) >>> 15;
    return neg ? -m : m;
  endfunction

  function automatic longint fx_shr(longint v, int k);
    longint m;
    m = ((v < 0 ? -v : v) + (64'sd1 << (k - 1))) >>> k;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint corner_fn(longint x, longint y, longint u);
    longint xy, br, p;
    xy = fx_mul(x, y);
    br = 4 * ONE - 3 * x - 3 * y + 2 * xy + 2 * u - fx_mul(x, u) - fx_mul(y, u)
         + 2 * fx_mul(xy, u);
    p = fx_mul(fx_mul(fx_mul(ONE + x, ONE + y), ONE - u), br);
    return -fx_shr(p, 4);
  endfunction

  function automatic longint apex_mid_fn(longint x, longint y, longint u);
    return fx_shr(fx_mul(fx_mul(ONE + x, ONE + y), ONE - fx_mul(u, u)), 2);
  endfunction

  function automatic longint base_mid_fn(longint x, longint y, longint u);
    longint br;
    br = 2 * ONE - y - fx_mul(y, u);
    return fx_shr(fx_mul(fx_mul(fx_mul(ONE - fx_mul(x, x), ONE + y), ONE - u), br), 3);
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // push the 13 expected coefficients of one point
  task automatic predict_shape(longint s, longint t, longint u);
    longint c[13];
    shape_res_t r;
    c[0] = fx_shr(fx_mul(u, ONE + u), 1);
    c[1] = corner_fn(-s, -t, u);
    c[2] = corner_fn(s, -t, u);
    c[3] = corner_fn(s, t, u);
    c[4] = corner_fn(-s, t, u);
    c[5] = apex_mid_fn(-s, -t, u);
    c[6] = apex_mid_fn(s, -t, u);
    c[7] = apex_mid_fn(s, t, u);
    c[8] = apex_mid_fn(-s, t, u);
    c[9] = base_mid_fn(s, -t, u);
    c[10] = base_mid_fn(t, s, u);
    c[11] = base_mid_fn(s, t, u);
    c[12] = base_mid_fn(t, -s, u);
    for (int k = 0; k < 13; k++) begin
      r.node = 4'(k);
      r.coef = clamp24(c[k]);
      r.last = (k == 12);
      coef_queue.push_back(r);
    end
  endtask

  // result side: random stall bursts, none while draining
  initial begin
    int gap;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!drain && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 17);
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    shape_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (coef_queue.size() == 0) begin
        $display("%0t: unexpected result node %0d coef %0d", $time, out_node_index,
                 out_coefficient);
        errors++;
      end else begin
        e = coef_queue.pop_front();
        if (out_node_index !== e.node) begin
          $display("%0t: node_index expected %0d actual %0d", $time, e.node, out_node_index);
          errors++;
        end
        if (out_coefficient !== e.coef) begin
          $display("%0t: coefficient node %0d expected %0d actual %0d", $time, e.node,
                   e.coef, out_coefficient);
          errors++;
        end
        if (out_last_node !== e.last) begin
          $display("%0t: last_node node %0d expected %0d actual %0d", $time, e.node,
                   e.last, out_last_node);
          errors++;
        end
      end
    end
  end

  task automatic send_point(logic signed [17:0] s, t, u);
    in_valid <= 1;
    in_coord_s <= s;
    in_coord_t <= t;
    in_coord_u <= u;
    do @(posedge clk); while (!in_ready);
    predict_shape(s, t, u);
    n_points++;
    @(negedge clk);
  endtask

  function automatic logic signed [17:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 18'($urandom);                             // full range
      1: return $signed(18'($urandom_range(0, 65536))) - 18'sd32768;  // -1..+1
      2: return $urandom_range(0, 1) ? 18'sh1FFFF : 18'sh20000;
      default: return $signed(18'($urandom_range(0, 16384) * 4)) - 18'sd32768;
    endcase
  endfunction

  initial begin
    point_row_t rows[$];
    point_row_t r;
    int gap;
    shape_res_t e;
    in_valid = 0;
    in_coord_s = 0;
    in_coord_t = 0;
    in_coord_u = 0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // origin, the apex, the four base corners, a base edge point, interior points, extremes
    rows.push_back('{0, 0, 0, 0, 0, 0});
    rows.push_back('{0, 0, 32768, 1, 32768, 0});
    rows.push_back('{32768, 32768, -32768, 1, 0, 32768});
    rows.push_back('{-32768, -32768, -32768, 0, 0, 0});
    rows.push_back('{32768, -32768, -32768, 0, 0, 0});
    rows.push_back('{-32768, 32768, -32768, 0, 0, 0});
    rows.push_back('{0, -32768, -32768, 0, 0, 0});
    rows.push_back('{16384, 16384, 0, 0, 0, 0});
    rows.push_back('{18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 0, 0, 0});
    rows.push_back('{18'sh20000, 18'sh20000, 18'sh20000, 0, 0, 0});
    rows.push_back('{18'sh1FFFF, 18'sh20000, 18'sh1FFFF, 0, 0, 0});
    rows.push_back('{18'sh20000, 18'sh1FFFF, 18'sh20000, 0, 0, 0});
    rows.push_back('{18'sh1FFFF, 0, 18'sh20000, 0, 0, 0});
    rows.push_back('{1, -1, 1, 0, 0, 0});
    rows.push_back('{-1, -1, -1, 0, 0, 0});
    rows.push_back('{18'sh15555, 18'sh2AAAA, 18'sh0AAAA, 0, 0, 0});
    rows.push_back('{18'sh2AAAA, 18'sh15555, 18'sh35555, 0, 0, 0});

    @(negedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      send_point(r.s, r.t, r.u);
      if (r.typed) begin
        // override predicted apex and corner 3 with values read off the formulas
        e = coef_queue[coef_queue.size() - 13];
        e.coef = 24'(r.c0);
        coef_queue[coef_queue.size() - 13] = e;
        e = coef_queue[coef_queue.size() - 10];
        e.coef = 24'(r.c1);
        coef_queue[coef_queue.size() - 10] = e;
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 30) drain = 1;
      if (!drain && $urandom_range(0, 4) == 0) begin
        in_valid <= 0;
        gap = $urandom_range(1, 17);
        repeat (gap) @(negedge clk);
      end
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 0;

    while (coef_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d points, checked %0d coefficients (extremes, nodes, random)",
             n_points, n_results);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### filelist.f
rtl/core/p13s_pkg.sv
rtl/core/p13s_front.sv
rtl/core/p13s_back.sv
rtl/core/pyramid13_shape_function_eval.sv
tb/tb.sv
